/* hw/rtl/afpm_pkg.sv */
package afpm_pkg;

    localparam int COEFF_W   = 16;
    localparam int CFG_IDX_W = 3;
    localparam int COLOR_W   = 24;

    localparam logic [7:0] PIX_ALPHA = 8'd255;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COEFF_XX      = 3'd0,
        REG_COEFF_XY      = 3'd1,
        REG_COEFF_YX      = 3'd2,
        REG_COEFF_YY      = 3'd3,
        REG_OFFSET_X      = 3'd4,
        REG_OFFSET_Y      = 3'd5,
        REG_CANVAS_WIDTH  = 3'd6,
        REG_CANVAS_HEIGHT = 3'd7
    } cfg_reg_t;

    typedef logic [COLOR_W-1:0] color_t;

endpackage

/* hw/rtl/affine_forward_pixel_mapper.sv */
// Forward-mapping affine pixel mapper. Each input transaction carries a source
// coordinate relative to the chosen origin and a BGR pixel; the block multiplies
// the coordinate by a 2x2 signed Q3.12 matrix, truncates each product term toward
// zero, adds the configured offset and tests the result against the canvas size.
// One output transaction is produced per input: the destination coordinate, a
// write-enable flag on tuser and an opaque BGRA pixel (coordinate and alpha are
// zero when the pixel falls off the canvas). The block accepts one pixel per clock
// while s_tready is high, which backpressure can drop; each pixel passes through
// the four register stages: multiply (loaded at acceptance), truncate, add offset,
// canvas compare. Each stage holds its data under backpressure and fills its
// bubble when it can, so stalls lose and repeat nothing. The user must see that
// registers are written only while the block is idle; the block itself does not
// enforce this. The coefficients reset to identity, offsets to zero and the
// canvas to its full coordinate range.
module affine_forward_pixel_mapper
    import afpm_pkg::*;
#(
    parameter int COORD_BITS = 13,
    parameter int FRAC_BITS  = 12
)
(
    input  logic clk,
    input  logic rst_n,

    input  logic                                                  cfg_we,
    input  logic [CFG_IDX_W-1:0]                                  cfg_index,
    input  logic [((COORD_BITS + 1 > 16) ? COORD_BITS + 1 : 16)-1:0] cfg_data,

    input  logic                                           s_tvalid,
    output logic                                           s_tready,
    // Fields from bit 0: src_x, src_y, blue_in, green_in, red_in, zero fill.
    input  logic [((2 * COORD_BITS + 24 + 7) / 8) * 8-1:0] s_tdata,

    output logic                                           m_tvalid,
    input  logic                                           m_tready,
    // Fields from bit 0: dest_x, dest_y, blue_out, green_out, red_out, alpha_out,
    // zero fill.
    output logic [((2 * COORD_BITS + 32 + 7) / 8) * 8-1:0] m_tdata,
    // Fields from bit 0: write_enable.
    output logic [0:0]                                     m_tuser
);

    localparam int SIZE_W = COORD_BITS + 1;
    localparam int OUT_W  = ((2 * COORD_BITS + 32 + 7) / 8) * 8;
    localparam int PROD_W = COEFF_W + COORD_BITS;
    localparam int TERM_W = PROD_W - FRAC_BITS;
    localparam int SUM_W  = ((TERM_W > SIZE_W) ? TERM_W : SIZE_W) + 2;

    logic signed [COEFF_W-1:0] coeff_xx_reg, coeff_xy_reg, coeff_yx_reg, coeff_yy_reg;
    logic signed [SIZE_W-1:0]  offset_x_reg, offset_y_reg;
    logic [SIZE_W-1:0]         canvas_width_reg, canvas_height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coeff_xx_reg      <= COEFF_W'(1 << FRAC_BITS);
            coeff_xy_reg      <= '0;
            coeff_yx_reg      <= '0;
            coeff_yy_reg      <= COEFF_W'(1 << FRAC_BITS);
            offset_x_reg      <= '0;
            offset_y_reg      <= '0;
            canvas_width_reg  <= SIZE_W'(1 << COORD_BITS);
            canvas_height_reg <= SIZE_W'(1 << COORD_BITS);
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_COEFF_XX:      coeff_xx_reg      <= cfg_data[COEFF_W-1:0];
                REG_COEFF_XY:      coeff_xy_reg      <= cfg_data[COEFF_W-1:0];
                REG_COEFF_YX:      coeff_yx_reg      <= cfg_data[COEFF_W-1:0];
                REG_COEFF_YY:      coeff_yy_reg      <= cfg_data[COEFF_W-1:0];
                REG_OFFSET_X:      offset_x_reg      <= cfg_data[SIZE_W-1:0];
                REG_OFFSET_Y:      offset_y_reg      <= cfg_data[SIZE_W-1:0];
                REG_CANVAS_WIDTH:  canvas_width_reg  <= cfg_data[SIZE_W-1:0];
                REG_CANVAS_HEIGHT: canvas_height_reg <= cfg_data[SIZE_W-1:0];
                default:           ;
            endcase
        end
    end

    // Stage handshake: a stage loads when it is empty or its successor loads.
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic v1_next, v2_next, v3_next, v4_next;
    logic rdy1, rdy2, rdy3, rdy4;

    assign rdy4     = !v4_reg || m_tready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = rdy1;
    assign m_tvalid = v4_reg;

    always_comb
    begin
        v1_next = rdy1 ? s_tvalid : v1_reg;
        v2_next = rdy2 ? v1_reg   : v2_reg;
        v3_next = rdy3 ? v2_reg   : v3_reg;
        v4_next = rdy4 ? v3_reg   : v4_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
        end
    end

    // Stage 1: the four products.
    logic signed [COORD_BITS-1:0] src_x, src_y;
    color_t                       color_in;
    logic signed [PROD_W-1:0]     mul_xx, mul_xy, mul_yx, mul_yy;
    logic signed [PROD_W-1:0]     prod_xx_reg, prod_xy_reg, prod_yx_reg, prod_yy_reg;
    color_t                       color1_reg;

    assign src_x    = s_tdata[COORD_BITS-1:0];
    assign src_y    = s_tdata[2*COORD_BITS-1:COORD_BITS];
    assign color_in = s_tdata[2*COORD_BITS+COLOR_W-1:2*COORD_BITS];

    assign mul_xx = PROD_W'(coeff_xx_reg) * PROD_W'(src_x);
    assign mul_xy = PROD_W'(coeff_xy_reg) * PROD_W'(src_y);
    assign mul_yx = PROD_W'(coeff_yx_reg) * PROD_W'(src_x);
    assign mul_yy = PROD_W'(coeff_yy_reg) * PROD_W'(src_y);

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            prod_xx_reg <= mul_xx;
            prod_xy_reg <= mul_xy;
            prod_yx_reg <= mul_yx;
            prod_yy_reg <= mul_yy;
            color1_reg  <= color_in;
        end
    end

    // Stage 2: scale each product down, truncating toward zero.
    function automatic logic signed [TERM_W-1:0] trunc_term(input logic signed [PROD_W-1:0] p);
        logic [PROD_W-1:0] biased;
        biased = p + {{TERM_W{1'b0}}, {FRAC_BITS{p[PROD_W-1]}}};
        return $signed(biased[PROD_W-1:FRAC_BITS]);
    endfunction

    logic signed [TERM_W-1:0] term_xx_reg, term_xy_reg, term_yx_reg, term_yy_reg;
    color_t                   color2_reg;

    always_ff @(posedge clk)
    begin
        if (rdy2)
        begin
            term_xx_reg <= trunc_term(prod_xx_reg);
            term_xy_reg <= trunc_term(prod_xy_reg);
            term_yx_reg <= trunc_term(prod_yx_reg);
            term_yy_reg <= trunc_term(prod_yy_reg);
            color2_reg  <= color1_reg;
        end
    end

    // Stage 3: sum the terms and the offset.
    logic signed [SUM_W-1:0] sum_x, sum_y;
    logic signed [SUM_W-1:0] sum_x_reg, sum_y_reg;
    color_t                  color3_reg;

    assign sum_x = SUM_W'(term_xx_reg) + SUM_W'(term_xy_reg) + SUM_W'(offset_x_reg);
    assign sum_y = SUM_W'(term_yx_reg) + SUM_W'(term_yy_reg) + SUM_W'(offset_y_reg);

    always_ff @(posedge clk)
    begin
        if (rdy3)
        begin
            sum_x_reg  <= sum_x;
            sum_y_reg  <= sum_y;
            color3_reg <= color2_reg;
        end
    end

    // Stage 4: canvas test and output formatting.
    logic                  in_x, in_y, on_canvas;
    logic [COORD_BITS-1:0] dest_x_reg, dest_y_reg;
    logic [7:0]            alpha_reg;
    logic                  write_enable_reg;
    color_t                color4_reg;

    assign in_x = (sum_x_reg[SUM_W-1:COORD_BITS] == '0)
               && (sum_x_reg < $signed(SUM_W'(canvas_width_reg)));
    assign in_y = (sum_y_reg[SUM_W-1:COORD_BITS] == '0)
               && (sum_y_reg < $signed(SUM_W'(canvas_height_reg)));
    assign on_canvas = in_x && in_y;

    always_ff @(posedge clk)
    begin
        if (rdy4)
        begin
            dest_x_reg       <= on_canvas ? sum_x_reg[COORD_BITS-1:0] : '0;
            dest_y_reg       <= on_canvas ? sum_y_reg[COORD_BITS-1:0] : '0;
            alpha_reg        <= on_canvas ? PIX_ALPHA : 8'd0;
            write_enable_reg <= on_canvas;
            color4_reg       <= color3_reg;
        end
    end

    assign m_tdata    = OUT_W'({alpha_reg, color4_reg, dest_y_reg, dest_x_reg});
    assign m_tuser[0] = write_enable_reg;

endmodule
